// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file of the vector unit.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle, outside reset.
`define HVA_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Expression must never hold, outside reset.
`define HVA_ASSERT_NEVER(name, clk, rst_n, expr) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");

`endif

// ===== hdl/hva_pkg.sv =====
// Package for the homogeneous vector unit: commands, constants, carried types
// and small helpers. Depends on nothing.
package hva_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int SQ_STEPS = 31;
	localparam int DIV_STEPS = 33;
	localparam int LATENCY = 4 + SQ_STEPS + 2 + DIV_STEPS + 1;

	localparam logic [31:0] MAX32 = 32'h7FFF_FFFF;
	localparam logic [31:0] MIN32 = 32'h8000_0000;

	typedef enum logic [3:0] {
		CMD_ADD   = 4'd0,
		CMD_SUB   = 4'd1,
		CMD_NEG   = 4'd2,
		CMD_SCALE = 4'd3,
		CMD_DIV   = 4'd4,
		CMD_NORM  = 4'd5,
		CMD_CROSS = 4'd6,
		CMD_DOT   = 4'd7,
		CMD_MAG   = 4'd8,
		CMD_POINT = 4'd9,
		CMD_EQUAL = 4'd10
	} cmd_e;

	typedef logic [3:0][31:0] vec_t;

	// Item state leaving the front end and riding through the root stages.
	typedef struct packed {
		cmd_e        cmd;
		vec_t        a;
		logic [31:0] f;
		vec_t        res;
		logic [31:0] sc;
		logic        truth;
		logic        fault;
		logic        pa;
		logic        ovf;
	} fr_t;

	typedef struct packed {
		fr_t         fr;
		logic [61:0] rem;
		logic [30:0] root;
	} sq_t;

	// Item state riding through the divider.
	typedef struct packed {
		vec_t        res;
		logic [31:0] sc;
		logic        truth;
		logic        fault;
		logic        use_div;
		logic [3:0]  neg;
	} ot_t;

	function automatic logic [31:0] sat33(input logic [32:0] v);
		logic [31:0] o;
		if (v[32] != v[31]) begin
			o = v[32] ? MIN32 : MAX32;
		end else begin
			o = v[31:0];
		end
		return o;
	endfunction

endpackage

// ===== hdl/hva_front.sv =====
// Front end of the vector unit: input register, lane multipliers, sums and
// rounding. Depends on hva_pkg.
module hva_front #(
	parameter int FRAC_BITS = hva_pkg::FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_v,
	input  hva_pkg::cmd_e cmd,
	input  hva_pkg::vec_t a,
	input  hva_pkg::vec_t b,
	input  logic [31:0]   f,
	input  logic [15:0]   tol,
	output logic          out_v,
	output hva_pkg::sq_t  out_d
);
	import hva_pkg::*;

	localparam logic signed [33:0] ONE  = 34'sd1 <<< FRAC_BITS;
	localparam logic signed [66:0] HALF = 67'sd1 <<< (FRAC_BITS - 1);
	localparam logic signed [66:0] HI   = 67'sd2147483647;
	localparam logic signed [66:0] LO   = -67'sd2147483648;

	function automatic logic near34(input logic [33:0] d, input logic [15:0] t);
		logic [33:0] m;
		m = d[33] ? (34'd0 - d) : d;
		return m < {18'd0, t};
	endfunction

	function automatic logic [31:0] round_sat(input logic signed [65:0] s);
		logic signed [66:0] t;
		logic [31:0] o;
		t = (67'(s) + HALF) >>> FRAC_BITS;
		if (t > HI) begin
			o = MAX32;
		end else if (t < LO) begin
			o = MIN32;
		end else begin
			o = t[31:0];
		end
		return o;
	endfunction

	// Stage 1: input register.
	logic v_s1, v_s2, v_s3;
	cmd_e cmd_s1, cmd_s2, cmd_s3;
	vec_t a_s1, b_s1, a_s2, a_s3;
	logic [31:0] f_s1, f_s2, f_s3;

	// Stage 2: multipliers and the simple operations.
	logic signed [31:0] ma [6];
	logic signed [31:0] mb [6];
	logic signed [63:0] p_s2 [6];
	vec_t res_c, res_s2, res_s3;
	logic truth_c, truth_s2, truth_s3;
	logic pa_c, pb_c, pa_s2, pb_s2, pa_s3, pb_s3;
	logic [3:0] eq_c;

	// Stage 3: sums.
	logic signed [65:0] sum_c [4];
	logic signed [65:0] sum_s3 [4];

	sq_t d_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			out_v <= 1'b0;
		end else begin
			v_s1  <= in_v;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			out_v <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1 <= cmd;
		a_s1   <= a;
		b_s1   <= b;
		f_s1   <= f;
	end

	always_comb begin
		pa_c = near34(34'($signed(a_s1[3])) - ONE, tol);
		pb_c = near34(34'($signed(b_s1[3])) - ONE, tol);
		for (int i = 0; i < 4; i++) begin
			eq_c[i] = near34(34'($signed(a_s1[i])) - 34'($signed(b_s1[i])), tol);
		end
	end

	always_comb begin
		for (int j = 0; j < 6; j++) begin
			ma[j] = '0;
			mb[j] = '0;
		end
		for (int i = 0; i < 4; i++) begin
			ma[i] = $signed(a_s1[i]);
			mb[i] = $signed(f_s1);
		end
		unique case (cmd_s1)
			CMD_DOT: begin
				for (int i = 0; i < 4; i++) mb[i] = $signed(b_s1[i]);
			end
			CMD_MAG, CMD_NORM: begin
				for (int i = 0; i < 4; i++) mb[i] = $signed(a_s1[i]);
			end
			CMD_CROSS: begin
				ma[0] = $signed(a_s1[1]); mb[0] = $signed(b_s1[2]);
				ma[1] = $signed(a_s1[2]); mb[1] = $signed(b_s1[1]);
				ma[2] = $signed(a_s1[2]); mb[2] = $signed(b_s1[0]);
				ma[3] = $signed(a_s1[0]); mb[3] = $signed(b_s1[2]);
				ma[4] = $signed(a_s1[0]); mb[4] = $signed(b_s1[1]);
				ma[5] = $signed(a_s1[1]); mb[5] = $signed(b_s1[0]);
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		res_c   = '0;
		truth_c = 1'b0;
		unique case (cmd_s1)
			CMD_ADD: begin
				for (int i = 0; i < 4; i++)
					res_c[i] = sat33(33'($signed(a_s1[i])) + 33'($signed(b_s1[i])));
			end
			CMD_SUB: begin
				for (int i = 0; i < 4; i++)
					res_c[i] = sat33(33'($signed(a_s1[i])) - 33'($signed(b_s1[i])));
			end
			CMD_NEG: begin
				for (int i = 0; i < 4; i++)
					res_c[i] = sat33(33'sd0 - 33'($signed(a_s1[i])));
			end
			CMD_POINT: truth_c = pa_c;
			CMD_EQUAL: truth_c = &eq_c;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < 6; j++) p_s2[j] <= ma[j] * mb[j];
		cmd_s2   <= cmd_s1;
		a_s2     <= a_s1;
		f_s2     <= f_s1;
		res_s2   <= res_c;
		truth_s2 <= truth_c;
		pa_s2    <= pa_c;
		pb_s2    <= pb_c;
	end

	always_comb begin
		for (int i = 0; i < 4; i++) sum_c[i] = 66'(p_s2[i]);
		unique case (cmd_s2)
			CMD_CROSS: begin
				sum_c[0] = 66'(p_s2[0]) - 66'(p_s2[1]);
				sum_c[1] = 66'(p_s2[2]) - 66'(p_s2[3]);
				sum_c[2] = 66'(p_s2[4]) - 66'(p_s2[5]);
				sum_c[3] = '0;
			end
			CMD_DOT, CMD_MAG, CMD_NORM: begin
				sum_c[0] = 66'(p_s2[0]) + 66'(p_s2[1]) + 66'(p_s2[2]) + 66'(p_s2[3]);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) sum_s3[i] <= sum_c[i];
		cmd_s3   <= cmd_s2;
		a_s3     <= a_s2;
		f_s3     <= f_s2;
		res_s3   <= res_s2;
		truth_s3 <= truth_s2;
		pa_s3    <= pa_s2;
		pb_s3    <= pb_s2;
	end

	// Stage 4: rounding, saturation and the point rules.
	always_comb begin
		d_c.fr.cmd   = cmd_s3;
		d_c.fr.a     = a_s3;
		d_c.fr.f     = f_s3;
		d_c.fr.res   = res_s3;
		d_c.fr.sc    = '0;
		d_c.fr.truth = truth_s3;
		d_c.fr.fault = 1'b0;
		d_c.fr.pa    = pa_s3;
		d_c.fr.ovf   = |sum_s3[0][65:62];
		d_c.rem      = sum_s3[0][61:0];
		d_c.root     = '0;
		unique case (cmd_s3)
			CMD_SCALE: begin
				for (int i = 0; i < 4; i++) d_c.fr.res[i] = round_sat(sum_s3[i]);
			end
			CMD_CROSS: begin
				if (pa_s3 || pb_s3) begin
					d_c.fr.fault = 1'b1;
				end else begin
					for (int i = 0; i < 3; i++) d_c.fr.res[i] = round_sat(sum_s3[i]);
				end
			end
			CMD_DOT: begin
				if (!pa_s3 && !pb_s3) d_c.fr.sc = round_sat(sum_s3[0]);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		out_d <= d_c;
	end

endmodule

// ===== hdl/hva_sqrt.sv =====
// Pipelined integer square root, one result bit per stage, carrying the item
// alongside. Depends on hva_pkg.
module hva_sqrt (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_v,
	input  hva_pkg::sq_t in_d,
	output logic         out_v,
	output hva_pkg::sq_t out_d
);
	import hva_pkg::*;

	sq_t sq_s [SQ_STEPS];
	logic [SQ_STEPS-1:0] vld_s;

	for (genvar j = 0; j < SQ_STEPS; j++) begin : g_step
		localparam int K = SQ_STEPS - 1 - j;
		sq_t cur, nx;
		logic cur_v;
		logic [61:0] t;

		if (j == 0) begin : g_first
			assign cur   = in_d;
			assign cur_v = in_v;
		end else begin : g_next
			assign cur   = sq_s[j-1];
			assign cur_v = vld_s[j-1];
		end

		// Trying the next root bit costs root * 2^(K+1) + 4^K.
		always_comb begin
			nx = cur;
			t  = (62'(cur.root) << (K + 1)) | (62'd1 << (2 * K));
			if (cur.rem >= t) begin
				nx.rem     = cur.rem - t;
				nx.root[K] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else begin
				vld_s[j] <= cur_v;
			end
		end

		always_ff @(posedge clk) begin
			sq_s[j] <= nx;
		end
	end

	assign out_v = vld_s[SQ_STEPS-1];
	assign out_d = sq_s[SQ_STEPS-1];

endmodule

// ===== hdl/hva_div.sv =====
// Length rounding, divisor selection and a pipelined four-lane restoring
// divider with the result register. Depends on hva_pkg.
module hva_div #(
	parameter int FRAC_BITS = hva_pkg::FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_v,
	input  hva_pkg::sq_t  in_d,
	input  logic [15:0]   tol,
	output logic          done,
	output hva_pkg::vec_t r,
	output logic [31:0]   r_scalar,
	output logic          truth,
	output logic          fault
);
	import hva_pkg::*;

	localparam int NW = 32 + FRAC_BITS;

	// Stage p1: length, divisor and special cases.
	logic [31:0] rr, len;
	ot_t ot_c, ot_p1, ot_p2;
	logic [31:0] d_c, d_p1, d_p2;
	vec_t mag_c, mag_p1;
	logic v_p1, v_p2;
	logic [NW-1:0] rem_p2 [4];

	// Divider iterations.
	logic [NW-1:0] rem_s [DIV_STEPS][4];
	logic [31:0]   q_s [DIV_STEPS][4];
	logic [3:0]    ovf_s [DIV_STEPS];
	ot_t           ot_s [DIV_STEPS];
	logic [31:0]   d_s [DIV_STEPS];
	logic [DIV_STEPS-1:0] vld_s;

	vec_t r_c;
	logic big;

	always_comb begin
		rr = {1'b0, in_d.root} + 32'(in_d.rem > 62'(in_d.root));
		if (in_d.fr.pa) begin
			len = '0;
		end else if (in_d.fr.ovf || rr[31]) begin
			len = MAX32;
		end else begin
			len = rr;
		end
	end

	always_comb begin
		ot_c.res     = in_d.fr.res;
		ot_c.sc      = in_d.fr.sc;
		ot_c.truth   = in_d.fr.truth;
		ot_c.fault   = in_d.fr.fault;
		ot_c.use_div = 1'b0;
		d_c          = len;
		for (int i = 0; i < 4; i++) begin
			ot_c.neg[i] = in_d.fr.a[i][31];
			mag_c[i]    = in_d.fr.a[i][31] ? (32'd0 - in_d.fr.a[i]) : in_d.fr.a[i];
		end
		unique case (in_d.fr.cmd)
			CMD_MAG: ot_c.sc = len;
			CMD_NORM: ot_c.use_div = (len != 32'd0) && (len >= {16'd0, tol});
			CMD_DIV: begin
				d_c = in_d.fr.f[31] ? (32'd0 - in_d.fr.f) : in_d.fr.f;
				if (in_d.fr.f == 32'd0) begin
					ot_c.fault = 1'b1;
					for (int i = 0; i < 4; i++) begin
						if (in_d.fr.a[i][31]) begin
							ot_c.res[i] = MIN32;
						end else if (in_d.fr.a[i] != 32'd0) begin
							ot_c.res[i] = MAX32;
						end else begin
							ot_c.res[i] = '0;
						end
					end
				end else begin
					ot_c.use_div = 1'b1;
					for (int i = 0; i < 4; i++)
						ot_c.neg[i] = in_d.fr.a[i][31] ^ in_d.fr.f[31];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p1 <= 1'b0;
			v_p2 <= 1'b0;
		end else begin
			v_p1 <= in_v;
			v_p2 <= v_p1;
		end
	end

	// Stage p2: rounded dividend, |a| * 2^FRAC_BITS + d/2.
	always_ff @(posedge clk) begin
		ot_p1  <= ot_c;
		d_p1   <= d_c;
		mag_p1 <= mag_c;
		ot_p2  <= ot_p1;
		d_p2   <= d_p1;
		for (int i = 0; i < 4; i++)
			rem_p2[i] <= {mag_p1[i], {FRAC_BITS{1'b0}}} + NW'(d_p1 >> 1);
	end

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_it
		logic [NW-1:0] nr [4];
		logic [31:0]   nq [4];
		logic [3:0]    no;
		ot_t           not_d;
		logic [31:0]   nd;
		logic          nv;

		if (j == 0) begin : g_first
			// A quotient of 2^32 or more saturates whatever its low bits.
			always_comb begin
				for (int i = 0; i < 4; i++) begin
					nr[i] = rem_p2[i];
					nq[i] = '0;
					no[i] = (rem_p2[i] >> 32) >= NW'(d_p2);
				end
			end
			assign not_d = ot_p2;
			assign nd    = d_p2;
			assign nv    = v_p2;
		end else begin : g_step
			localparam int K = DIV_STEPS - 1 - j;
			always_comb begin
				for (int i = 0; i < 4; i++) begin
					nr[i] = rem_s[j-1][i];
					nq[i] = q_s[j-1][i];
					if ((rem_s[j-1][i] >> K) >= NW'(d_s[j-1])) begin
						nr[i]    = rem_s[j-1][i] - (NW'(d_s[j-1]) << K);
						nq[i][K] = 1'b1;
					end
				end
			end
			assign no    = ovf_s[j-1];
			assign not_d = ot_s[j-1];
			assign nd    = d_s[j-1];
			assign nv    = vld_s[j-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else begin
				vld_s[j] <= nv;
			end
		end

		always_ff @(posedge clk) begin
			for (int i = 0; i < 4; i++) begin
				rem_s[j][i] <= nr[i];
				q_s[j][i]   <= nq[i];
			end
			ovf_s[j] <= no;
			ot_s[j]  <= not_d;
			d_s[j]   <= nd;
		end
	end

	// Sign and saturation; the magnitude is capped at 2^31.
	always_comb begin
		big = 1'b0;
		for (int i = 0; i < 4; i++) begin
			big = ovf_s[DIV_STEPS-1][i] || q_s[DIV_STEPS-1][i][31];
			if (!ot_s[DIV_STEPS-1].use_div) begin
				r_c[i] = ot_s[DIV_STEPS-1].res[i];
			end else if (ot_s[DIV_STEPS-1].neg[i]) begin
				r_c[i] = big ? MIN32 : (32'd0 - q_s[DIV_STEPS-1][i]);
			end else begin
				r_c[i] = big ? MAX32 : q_s[DIV_STEPS-1][i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_s[DIV_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		r        <= r_c;
		r_scalar <= ot_s[DIV_STEPS-1].sc;
		truth    <= ot_s[DIV_STEPS-1].truth;
		fault    <= ot_s[DIV_STEPS-1].fault;
	end

endmodule

// ===== hdl/homogeneous_vector_alu.sv =====
// Top level of the homogeneous four-component vector unit.
// Depends on hva_pkg, hva_front, hva_sqrt and hva_div.

// The unit takes one item per clock: busy never rises, so an item is taken at
// every edge where start is high. Each item comes out with done high for one
// cycle, in the order the items went in; the receiver cannot hold results off,
// so they must be captured on the done cycle. Every item takes the same path
// whatever its command and FRAC_BITS: the input register, multiplier, sum and
// rounding stages, the square root stages (one root bit per stage, for
// magnitude and normalize), the stages that form the divisor and the rounded
// dividend, the divider stages (an overflow check and one quotient bit per
// stage, four lanes wide) and the result register. All components are signed
// fixed point with FRAC_BITS fraction bits and every result saturates to 32
// bits. The tolerance register resets to one LSB and sets the point test on w,
// the equality test and the least length that normalize divides by; it is
// written through the cfg channel, which is always ready, and must be written
// only while no item is in flight.
module homogeneous_vector_alu #(
	parameter int FRAC_BITS = hva_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [3:0]         cmd,
	input  logic signed [31:0] a_x,
	input  logic signed [31:0] a_y,
	input  logic signed [31:0] a_z,
	input  logic signed [31:0] a_w,
	input  logic signed [31:0] b_x,
	input  logic signed [31:0] b_y,
	input  logic signed [31:0] b_z,
	input  logic signed [31:0] b_w,
	input  logic signed [31:0] factor,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        cfg_data,
	output logic               done,
	output logic signed [31:0] r_x,
	output logic signed [31:0] r_y,
	output logic signed [31:0] r_z,
	output logic signed [31:0] r_w,
	output logic signed [31:0] r_scalar,
	output logic               truth,
	output logic               fault
);
	import hva_pkg::*;

	logic [15:0] tolerance_q;
	vec_t a_v, b_v, r_v;
	logic front_v, sqrt_v;
	sq_t front_d, sqrt_d;

	// Every stage advances each cycle, so the unit is never busy.
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance_q <= 16'd1;
		end else if (cfg_valid && cfg_ready) begin
			tolerance_q <= cfg_data;
		end
	end

	// Lane 0 is x, lane 3 is w.
	assign a_v = {a_w, a_z, a_y, a_x};
	assign b_v = {b_w, b_z, b_y, b_x};

	hva_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_v   (start && !busy),
		.cmd    (cmd_e'(cmd)),
		.a      (a_v),
		.b      (b_v),
		.f      (factor),
		.tol    (tolerance_q),
		.out_v  (front_v),
		.out_d  (front_d)
	);

	hva_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.in_v   (front_v),
		.in_d   (front_d),
		.out_v  (sqrt_v),
		.out_d  (sqrt_d)
	);

	hva_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_v     (sqrt_v),
		.in_d     (sqrt_d),
		.tol      (tolerance_q),
		.done     (done),
		.r        (r_v),
		.r_scalar (r_scalar),
		.truth    (truth),
		.fault    (fault)
	);

	assign r_x = r_v[0];
	assign r_y = r_v[1];
	assign r_z = r_v[2];
	assign r_w = r_v[3];

endmodule

// ===== hdl/hva_checker.sv =====
// Port-level checker for the vector unit and its bind to the top level.
// Depends on hva_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hva_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic        done,
	input logic [31:0] r_x,
	input logic [31:0] r_y,
	input logic [31:0] r_z,
	input logic [31:0] r_w,
	input logic [31:0] r_scalar,
	input logic        truth,
	input logic        fault
);
	import hva_pkg::*;

	logic r_zero;

	assign r_zero = (r_x == 32'd0) && (r_y == 32'd0) && (r_z == 32'd0) && (r_w == 32'd0);

	// A result only ever follows an item taken a fixed latency earlier.
	`HVA_ASSERT_IMPL(a_latency, clk, arst_n, done, $past(start && !busy, LATENCY))
	// Test commands give a zero tuple and zero scalar and never fault.
	`HVA_ASSERT_IMPL(a_truth_clean, clk, arst_n, done && truth, r_zero && r_scalar == 0 && !fault)
	// Faults come only from divide or cross, which leave the scalar at zero.
	`HVA_ASSERT_IMPL(a_fault_clean, clk, arst_n, done && fault, r_scalar == 0 && !truth)
	// The pipeline never pushes back on either channel.
	`HVA_ASSERT_NEVER(a_no_stall, clk, arst_n, busy || !cfg_ready || (cfg_valid && !cfg_ready))

endmodule

bind homogeneous_vector_alu hva_checker u_hva_checker (.*);
